@@ rtl/rpn_stack_calculator_assert.svh @@
// ----------------------------------------------------------------------------
// RPN stack calculator assertion macros
// Shared concurrent assertion forms used by the calculator RTL.
// ----------------------------------------------------------------------------
`ifndef RPN_STACK_CALCULATOR_ASSERT_SVH
`define RPN_STACK_CALCULATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSC_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rsc: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RSC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rsc: assertion failed");

`endif

@@ rtl/rsc_pkg.sv @@
// ----------------------------------------------------------------------------
// RPN stack calculator package
// Operation codes, status codes, state types and control bundles.
// ----------------------------------------------------------------------------
package rsc_pkg;

   localparam int unsigned VALUE_W = 32;
   localparam int unsigned FUNC_W  = 3;
   localparam int unsigned DEPTH_W = 8;
   localparam int unsigned MAG_W   = 48;
   localparam int unsigned DIV_STEPS = 48;
   localparam int unsigned STEP_W  = $clog2(DIV_STEPS);

   localparam logic [FUNC_W-1:0] FUNC_PUSH = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_ADD  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_SUB  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_MUL  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_DIV  = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_POP  = 3'd5;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_UNDERFLOW = 2'd2,
      STATUS_DIV_ZERO  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_FETCH,
      SEQ_EXEC,
      SEQ_REFILL,
      SEQ_DONE
   } seq_state_type;

   typedef enum logic [1:0] {
      ALU_IDLE,
      ALU_DIV,
      ALU_SAT
   } alu_state_type;

   typedef struct packed {
      logic              start;
      logic [FUNC_W-1:0] func;
   } alu_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } alu_sts_type;

endpackage

@@ rtl/rsc_req_if.sv @@
// ----------------------------------------------------------------------------
// RPN stack calculator request channel
// Valid/ready channel carrying one operation and its push operand.
// ----------------------------------------------------------------------------
interface rsc_req_if;

   logic                                valid;
   logic                                ready;
   logic [rsc_pkg::FUNC_W-1:0]          func;
   logic signed [rsc_pkg::VALUE_W-1:0]  operand_value;

   modport source (output valid, output func, output operand_value, input ready);
   modport sink (input valid, input func, input operand_value, output ready);

endinterface

@@ rtl/rsc_rsp_if.sv @@
// ----------------------------------------------------------------------------
// RPN stack calculator response channel
// Valid/ready channel carrying the result, status and stack depth.
// ----------------------------------------------------------------------------
interface rsc_rsp_if;

   logic                                valid;
   logic                                ready;
   logic signed [rsc_pkg::VALUE_W-1:0]  result_value;
   logic [1:0]                          status;
   logic [rsc_pkg::DEPTH_W-1:0]         stack_depth;

   modport source (output valid, output result_value, output status, output stack_depth,
                   input ready);
   modport sink (input valid, input result_value, input status, input stack_depth,
                 output ready);

endinterface

@@ rtl/rsc_stack_mem.sv @@
// ----------------------------------------------------------------------------
// RPN stack calculator operand memory
// Single write port, single registered read port holding the entries below the top.
// ----------------------------------------------------------------------------
module rsc_stack_mem #(
   parameter int unsigned DEPTH = 128,
   parameter int unsigned AW    = 7
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [AW-1:0]                wr_addr,
   input  logic [rsc_pkg::VALUE_W-1:0]  wr_data,
   input  logic [AW-1:0]                rd_addr,
   output logic [rsc_pkg::VALUE_W-1:0]  rd_data
);

   logic [rsc_pkg::VALUE_W-1:0] mem [DEPTH];
   logic [rsc_pkg::VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/rsc_alu.sv @@
// ----------------------------------------------------------------------------
// RPN stack calculator arithmetic unit
// Saturating Q16.16 add, subtract, multiply and restoring divide.
// ----------------------------------------------------------------------------
module rsc_alu (
   input  logic                                clock,
   input  logic                                reset,
   input  rsc_pkg::alu_cmd_type                cmd,
   input  logic signed [rsc_pkg::VALUE_W-1:0]  operand_a,
   input  logic signed [rsc_pkg::VALUE_W-1:0]  operand_b,
   output rsc_pkg::alu_sts_type                sts,
   output logic signed [rsc_pkg::VALUE_W-1:0]  result
);

   function automatic logic [31:0] sat_sum(input logic [32:0] sum);
      logic [31:0] value;
      if (sum[32] != sum[31]) begin
         value = sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         value = sum[31:0];
      end
      return value;
   endfunction

   function automatic logic [31:0] sign_sat(input logic [47:0] mag, input logic neg);
      logic [31:0] value;
      if (neg) begin
         value = (mag > 48'h0000_8000_0000) ? 32'h8000_0000 : (~mag[31:0] + 32'd1);
      end else begin
         value = (mag > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
      end
      return value;
   endfunction

   rsc_pkg::alu_state_type          state_ff, state_in;
   logic                            neg_ff, neg_in;
   logic [rsc_pkg::MAG_W-1:0]       mag_ff, mag_in;
   logic [31:0]                     rem_ff, rem_in;
   logic [31:0]                     div_ff, div_in;
   logic [rsc_pkg::STEP_W-1:0]      step_ff, step_in;
   logic [31:0]                     result_ff, result_in;
   logic                            done_ff, done_in;

   logic [31:0] mag_a;
   logic [31:0] mag_b;
   logic [63:0] product;
   logic [32:0] shifted;
   logic [32:0] trial;
   logic        fits;

   assign mag_a   = operand_a[31] ? (~operand_a + 32'd1) : operand_a;
   assign mag_b   = operand_b[31] ? (~operand_b + 32'd1) : operand_b;
   assign product = {32'd0, mag_a} * {32'd0, mag_b};
   assign shifted = {rem_ff, mag_ff[rsc_pkg::MAG_W-1]};
   assign trial   = shifted - {1'b0, div_ff};
   assign fits    = shifted >= {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rsc_pkg::ALU_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      neg_ff    <= neg_in;
      mag_ff    <= mag_in;
      rem_ff    <= rem_in;
      div_ff    <= div_in;
      step_ff   <= step_in;
      result_ff <= result_in;
   end

   always_comb begin
      state_in  = state_ff;
      neg_in    = neg_ff;
      mag_in    = mag_ff;
      rem_in    = rem_ff;
      div_in    = div_ff;
      step_in   = step_ff;
      result_in = result_ff;
      done_in   = 1'b0;
      unique case (state_ff)
         rsc_pkg::ALU_IDLE: begin
            if (cmd.start) begin
               neg_in = operand_a[31] ^ operand_b[31];
               unique case (cmd.func)
                  rsc_pkg::FUNC_ADD: begin
                     result_in = sat_sum({operand_a[31], operand_a} + {operand_b[31], operand_b});
                     done_in   = 1'b1;
                  end
                  rsc_pkg::FUNC_SUB: begin
                     result_in = sat_sum({operand_a[31], operand_a} - {operand_b[31], operand_b});
                     done_in   = 1'b1;
                  end
                  rsc_pkg::FUNC_MUL: begin
                     mag_in   = product[63:16];
                     state_in = rsc_pkg::ALU_SAT;
                  end
                  rsc_pkg::FUNC_DIV: begin
                     mag_in   = {mag_a, 16'd0};
                     rem_in   = 32'd0;
                     div_in   = mag_b;
                     step_in  = rsc_pkg::STEP_W'(rsc_pkg::DIV_STEPS - 1);
                     state_in = rsc_pkg::ALU_DIV;
                  end
                  default: begin
                     result_in = 32'd0;
                     done_in   = 1'b1;
                  end
               endcase
            end
         end
         rsc_pkg::ALU_DIV: begin
            rem_in  = fits ? trial[31:0] : shifted[31:0];
            mag_in  = {mag_ff[rsc_pkg::MAG_W-2:0], fits};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = rsc_pkg::ALU_SAT;
            end
         end
         rsc_pkg::ALU_SAT: begin
            result_in = sign_sat(mag_ff, neg_ff);
            done_in   = 1'b1;
            state_in  = rsc_pkg::ALU_IDLE;
         end
         default: begin
            state_in = rsc_pkg::ALU_IDLE;
         end
      endcase
   end

   assign sts.busy = (state_ff != rsc_pkg::ALU_IDLE);
   assign sts.done = done_ff;
   assign result   = result_ff;

endmodule

@@ rtl/rpn_stack_calculator.sv @@
// ----------------------------------------------------------------------------
// RPN stack calculator
// Reverse Polish evaluator over a stack of signed Q16.16 values.
//
//   Channel   Direction   Payload
//   req_chan  in          func, operand_value
//   rsp_chan  out         result_value, status, stack_depth
//
// Add, subtract and multiply are done in the arithmetic unit; divide in its
// restoring divider, which produces one quotient bit per cycle. One item is
// worked at a time.
// Reset is synchronous and empties the stack; memory contents are not cleared.
// A stalled response is held in the output register while the next request
// is taken.
// ----------------------------------------------------------------------------
`include "rpn_stack_calculator_assert.svh"

module rpn_stack_calculator #(
   parameter int unsigned STACK_DEPTH = 128
) (
   input  logic     clock,
   input  logic     reset,
   rsc_req_if.sink   req_chan,
   rsc_rsp_if.source rsp_chan
);

   localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
   localparam int unsigned AW = $clog2(STACK_DEPTH);
   localparam logic [CW-1:0] DEPTH_CW = CW'(STACK_DEPTH);

   rsc_pkg::seq_state_type             state_ff, state_in;
   logic [CW-1:0]                      count_ff, count_in;
   logic [rsc_pkg::VALUE_W-1:0]        top_ff, top_in;
   logic [rsc_pkg::FUNC_W-1:0]         func_ff, func_in;
   logic [rsc_pkg::VALUE_W-1:0]        res_ff, res_in;
   rsc_pkg::status_type                status_ff, status_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [rsc_pkg::VALUE_W-1:0]        rsp_value_ff, rsp_value_in;
   rsc_pkg::status_type                rsp_status_ff, rsp_status_in;
   logic [rsc_pkg::DEPTH_W-1:0]        rsp_depth_ff, rsp_depth_in;

   logic                               req_fire;
   logic [CW-1:0]                      count_minus1;
   logic [CW-1:0]                      count_minus2;
   logic [CW+rsc_pkg::DEPTH_W-1:0]     count_ext;
   logic [rsc_pkg::VALUE_W-1:0]        top_or_zero;
   logic                               wr_en;
   logic [AW-1:0]                      wr_addr;
   logic [rsc_pkg::VALUE_W-1:0]        wr_data;
   logic [rsc_pkg::VALUE_W-1:0]        rd_data;
   rsc_pkg::alu_cmd_type               alu_cmd;
   rsc_pkg::alu_sts_type               alu_sts;
   logic signed [rsc_pkg::VALUE_W-1:0] alu_result;

   assign req_chan.ready = (state_ff == rsc_pkg::SEQ_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign count_minus1   = count_ff - 1'b1;
   assign count_minus2   = count_ff - 2'd2;
   assign count_ext      = {{rsc_pkg::DEPTH_W{1'b0}}, count_ff};
   assign top_or_zero    = (count_ff != '0) ? top_ff : '0;

   rsc_stack_mem #(
      .DEPTH (STACK_DEPTH),
      .AW    (AW)
   ) u_stack_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (count_minus2[AW-1:0]),
      .rd_data (rd_data)
   );

   rsc_alu u_alu (
      .clock     (clock),
      .reset     (reset),
      .cmd       (alu_cmd),
      .operand_a (rd_data),
      .operand_b (top_ff),
      .sts       (alu_sts),
      .result    (alu_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rsc_pkg::SEQ_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      top_ff        <= top_in;
      func_ff       <= func_in;
      res_ff        <= res_in;
      status_ff     <= status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_depth_ff  <= rsp_depth_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      top_in        = top_ff;
      func_in       = func_ff;
      res_in        = res_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_depth_in  = rsp_depth_ff;
      wr_en         = 1'b0;
      wr_addr       = count_minus1[AW-1:0];
      wr_data       = top_ff;
      alu_cmd.start = 1'b0;
      alu_cmd.func  = func_ff;
      unique case (state_ff)
         rsc_pkg::SEQ_IDLE: begin
            if (req_fire) begin
               func_in   = req_chan.func;
               status_in = rsc_pkg::STATUS_OK;
               state_in  = rsc_pkg::SEQ_DONE;
               unique case (req_chan.func)
                  rsc_pkg::FUNC_PUSH: begin
                     if (count_ff == DEPTH_CW) begin
                        status_in = rsc_pkg::STATUS_OVERFLOW;
                        res_in    = top_or_zero;
                     end else begin
                        wr_en    = (count_ff != '0);
                        top_in   = req_chan.operand_value;
                        count_in = count_ff + 1'b1;
                        res_in   = req_chan.operand_value;
                     end
                  end
                  rsc_pkg::FUNC_ADD, rsc_pkg::FUNC_SUB, rsc_pkg::FUNC_MUL,
                  rsc_pkg::FUNC_DIV: begin
                     if (count_ff < CW'(2)) begin
                        status_in = rsc_pkg::STATUS_UNDERFLOW;
                        res_in    = top_or_zero;
                     end else begin
                        state_in = rsc_pkg::SEQ_FETCH;
                     end
                  end
                  rsc_pkg::FUNC_POP: begin
                     if (count_ff == '0) begin
                        status_in = rsc_pkg::STATUS_UNDERFLOW;
                        res_in    = '0;
                     end else begin
                        res_in   = top_ff;
                        count_in = count_minus1;
                        if (count_ff >= CW'(2)) begin
                           state_in = rsc_pkg::SEQ_REFILL;
                        end
                     end
                  end
                  default: begin
                     res_in = top_or_zero;
                  end
               endcase
            end
         end
         rsc_pkg::SEQ_FETCH: begin
            if ((func_ff == rsc_pkg::FUNC_DIV) && (top_ff == '0)) begin
               status_in = rsc_pkg::STATUS_DIV_ZERO;
               res_in    = top_ff;
               state_in  = rsc_pkg::SEQ_DONE;
            end else begin
               alu_cmd.start = 1'b1;
               state_in      = rsc_pkg::SEQ_EXEC;
            end
         end
         rsc_pkg::SEQ_EXEC: begin
            if (alu_sts.done) begin
               top_in   = alu_result;
               res_in   = alu_result;
               count_in = count_minus1;
               state_in = rsc_pkg::SEQ_DONE;
            end
         end
         rsc_pkg::SEQ_REFILL: begin
            top_in   = rd_data;
            state_in = rsc_pkg::SEQ_DONE;
         end
         rsc_pkg::SEQ_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_ff;
               rsp_status_in = status_ff;
               rsp_depth_in  = count_ext[rsc_pkg::DEPTH_W-1:0];
               state_in      = rsc_pkg::SEQ_IDLE;
            end
         end
         default: begin
            state_in = rsc_pkg::SEQ_IDLE;
         end
      endcase
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.result_value = rsp_value_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.stack_depth  = rsp_depth_ff;

   `RSC_ASSERT_SAME(a_count_range, clock, reset, 1'b1, count_ff <= DEPTH_CW)
   `RSC_ASSERT_NEXT(a_push_grows, clock, reset,
      req_fire && (req_chan.func == rsc_pkg::FUNC_PUSH) && (count_ff != DEPTH_CW),
      count_ff == CW'($past(count_ff) + 1'b1))
   `RSC_ASSERT_SAME(a_alu_start_idle, clock, reset, alu_cmd.start, !alu_sts.busy)
   `RSC_ASSERT_SAME(a_alu_done_exec, clock, reset, alu_sts.done,
      state_ff == rsc_pkg::SEQ_EXEC)

endmodule
